// ----- sv/spq_pkg.sv -----
package spq_pkg;

    // operation codes of an input transfer
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_SEARCH = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NONE = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    // priority reported when no entry is returned
    localparam logic [1:0] NONE_PRIORITY = 2'd3;

    // one queue entry
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] payload;
        logic [1:0]  pri;
    } t_entry;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_PULL,
        CELL_ROTATE
    } t_cell_op;

    // control broadcast along the chain
    typedef struct packed {
        t_cell_op op;
        t_entry   ins;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ----- sv/stable_priority_queue_unit.sv -----
// Stable priority queue, lower priority value served first, equal
// priorities first in first out.
// Input channel i_valid/o_ready carries an operation in i_kind with
// i_patient_tag, i_payload and i_priority_req. Output channel
// o_valid/i_ready carries one result per operation: status, entry fields
// and the occupancy after the operation.
// Entries sit in a row of cells, head in cell 0. For insert, remove and
// peek the result appears in the output register on the cycle after the
// transfer, and a new operation is taken every cycle while no search is
// running and the output register is free or being drained.
// A search rotates the whole row through the head cell, one cell per
// cycle, comparing tags there; the result shows once every entry has passed
// the head, and the row ends in its original order. A search on an
// empty queue answers like a peek.
// Reset empties the queue and clears the output valid; stored entries are
// not cleared. When the receiver stalls, the result holds in the output
// register and no further operation is taken until it is accepted.
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_patient_tag,
    input  logic [31:0] i_payload,
    input  logic [1:0]  i_priority_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_tag,
    output logic [31:0] o_out_payload,
    output logic [1:0]  o_out_priority,
    output logic [4:0]  o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scan, n_scan;
    logic [15:0]   r_target;
    logic          r_found, n_found;
    t_entry        r_hit, n_hit;
    logic          r_out_valid;
    logic          n_out_load;
    logic [1:0]    r_status, n_status;
    t_entry        r_out, n_out;
    logic [4:0]    r_occ;
    logic [CW+4:0] w_count_ext;

    t_cell_ctl     w_ctl;
    t_entry        w_ent  [CAPACITY];
    logic          w_keep [CAPACITY];
    t_entry        w_head;
    t_entry        w_none;
    t_entry        w_zero;
    logic          w_in_xfer;
    logic          w_out_free;
    logic          w_full;
    logic          w_empty;
    logic          w_scan_end;

    assign w_head     = w_ent[0];
    assign w_none     = '{tag: 16'd0, payload: 32'd0, pri: NONE_PRIORITY};
    assign w_zero     = '{tag: 16'd0, payload: 32'd0, pri: 2'd0};
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign w_in_xfer  = i_valid && o_ready;
    assign w_full     = r_count == CW'(CAPACITY);
    assign w_empty    = r_count == '0;
    assign w_scan_end = r_scan == (r_count - CW'(1));

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_keep;
        t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left      = w_zero;
            assign w_left_keep = 1'b1;
        end else begin : g_mid
            assign w_left      = w_ent[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_head;
        end else begin : g_inner
            assign w_right = w_ent[g+1];
        end

        spq_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .i_head      (w_head),
            .o_ent       (w_ent[g]),
            .o_keep      (w_keep[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (t_kind'(i_kind) == KIND_SEARCH) && !w_empty) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // cell control, count, scan and result
    always_comb begin
        w_ctl.op   = CELL_HOLD;
        w_ctl.ins  = '{tag: i_patient_tag, payload: i_payload, pri: i_priority_req};
        n_count    = r_count;
        n_scan     = r_scan;
        n_found    = r_found;
        n_hit      = r_hit;
        n_out_load = 1'b0;
        n_status   = r_status;
        n_out      = r_out;
        case (r_state)
            ST_IDLE: begin
                n_scan  = '0;
                n_found = 1'b0;
                if (w_in_xfer) begin
                    n_out_load = 1'b1;
                    n_status   = STAT_NONE;
                    n_out      = w_none;
                    case (t_kind'(i_kind))
                        KIND_INSERT: begin
                            n_out = w_zero;
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + CW'(1);
                                n_status = STAT_OK;
                            end
                        end
                        KIND_REMOVE: begin
                            if (!w_empty) begin
                                w_ctl.op = CELL_PULL;
                                n_count  = r_count - CW'(1);
                                n_status = STAT_OK;
                                n_out    = w_head;
                            end
                        end
                        KIND_PEEK: begin
                            if (!w_empty) begin
                                n_status = STAT_OK;
                                n_out    = w_head;
                            end
                        end
                        KIND_SEARCH: begin
                            // non-empty search goes to the scan, result comes later
                            n_out_load = w_empty;
                        end
                        default: n_out_load = 1'b0;
                    endcase
                end
            end
            ST_SCAN: begin
                // rotate the row and test the entry at the head
                w_ctl.op = CELL_ROTATE;
                n_scan   = r_scan + CW'(1);
                if (!r_found && (w_head.tag == r_target)) begin
                    n_found = 1'b1;
                    n_hit   = w_head;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_load = 1'b1;
                    n_status   = r_found ? STAT_OK : STAT_NONE;
                    n_out      = r_found ? r_hit : w_none;
                end
            end
            default: w_ctl.op = CELL_HOLD;
        endcase
    end

    // occupancy is the count taken modulo 32
    assign w_count_ext = {5'd0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan bookkeeping and output payload
    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_found <= n_found;
        r_hit   <= n_hit;
        if (w_in_xfer) begin
            r_target <= i_patient_tag;
        end
        if (n_out_load) begin
            r_status <= n_status;
            r_out    <= n_out;
            r_occ    <= w_count_ext[4:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_tag      = r_out.tag;
    assign o_out_payload  = r_out.payload;
    assign o_out_priority = r_out.pri;
    assign o_occupancy    = r_occ;

endmodule

// ----- sv/spq_cell.sv -----
module spq_cell
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IDX      = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  t_entry        i_left,
    input  logic          i_left_keep,
    input  t_entry        i_right,
    input  t_entry        i_head,
    output t_entry        o_ent,
    output logic          o_keep
);

    t_entry r_ent;
    t_entry n_ent;
    logic   w_valid;
    logic   w_last;

    // occupancy of this slot follows from the entry count
    assign w_valid = CW'(IDX) < i_count;
    assign w_last  = CW'(IDX + 1) == i_count;

    // entry stays ahead of the new one when its priority is equal or better
    assign o_keep = w_valid && (r_ent.pri <= i_ctl.ins.pri);
    assign o_ent  = r_ent;

    // next slot contents
    always_comb begin
        n_ent = r_ent;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (!o_keep) begin
                    n_ent = i_left_keep ? i_ctl.ins : i_left;
                end
            end
            CELL_PULL:   n_ent = i_right;
            CELL_ROTATE: n_ent = w_last ? i_head : i_right;
            default:     n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

// ----- sv/spq_checker.sv -----
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_patient_tag,
    input logic [31:0] i_payload,
    input logic [1:0]  i_priority_req,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_out_tag,
    input logic [31:0] o_out_payload,
    input logic [1:0]  o_out_priority,
    input logic [4:0]  o_occupancy
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // occupancy stays within the capacity
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((CAPACITY >= 32) || (32'(o_occupancy) <= CAPACITY)))
        else $error("occupancy beyond capacity");

    // a missing entry reads as all zero with the none priority
    a_none_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_NONE)) |->
        ((o_out_tag == 16'd0) && (o_out_payload == 32'd0)
         && (o_out_priority == NONE_PRIORITY)))
        else $error("empty result carries data");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
        (o_valid && $stable(o_status) && $stable(o_out_tag) && $stable(o_out_payload)
         && $stable(o_occupancy)))
        else $error("stalled result changed");

endmodule

bind stable_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import spq_pkg::*;

    localparam int CAP            = 16;
    localparam int N_RANDOM       = 1875;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_AT     = 600;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int CALM_TAIL      = 150;
    localparam int REPORT_MAX     = 10;
    localparam int DRAIN_CYCLES   = 40;

    // one operation offered on the input channel, or a pause marker
    typedef struct {
        t_kind       kind;
        logic [15:0] tag;
        logic [31:0] payload;
        logic [1:0]  pri;
        bit          drain;
    } t_queue_op;

    // one response as seen on the output channel
    typedef struct packed {
        t_status     status;
        logic [15:0] tag;
        logic [31:0] payload;
        logic [1:0]  pri;
        logic [4:0]  occ;
    } t_queue_resp;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind         = 2'd0;
    logic [15:0] i_patient_tag  = 16'd0;
    logic [31:0] i_payload      = 32'd0;
    logic [1:0]  i_priority_req = 2'd0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_out_tag;
    logic [31:0] o_out_payload;
    logic [1:0]  o_out_priority;
    logic [4:0]  o_occupancy;

    t_queue_op   pending_ops[$];
    t_queue_resp expected_resps[$];
    t_queue_op   offered_op;

    // shadow copy of the queue contents, head at index 0
    t_entry      shadow_slots[CAP];
    int          shadow_count = 0;

    bit          op_taken     = 1'b0;
    bit          tail_calm    = 1'b0;
    int          ops_accepted = 0;
    int          resps_checked = 0;
    int          mismatches   = 0;
    int          idle_cycles  = 0;
    int          n_dropped    = 0;
    int          n_missing    = 0;
    int          n_search_hit = 0;
    int          n_pauses     = 0;

    int          send_gap = 0;
    int          send_idle_pct = 0;
    int          send_cycle = 0;
    int          recv_gap = 0;
    int          recv_idle_pct = 0;
    int          recv_cycle = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    stable_priority_queue_unit #(
        .CAPACITY(CAP)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_patient_tag  (i_patient_tag),
        .i_payload      (i_payload),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_tag      (o_out_tag),
        .o_out_payload  (o_out_payload),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // apply one operation to the shadow queue and return the response it gives
    function automatic t_queue_resp apply_queue_op(t_queue_op op);
        t_queue_resp r;
        int          pos;
        int          k;
        bit          hit;
        r   = '{STAT_OK, 16'd0, 32'd0, 2'd0, 5'd0};
        hit = 1'b0;
        case (op.kind)
            KIND_INSERT: begin
                if (shadow_count >= CAP) begin
                    r.status = STAT_FULL;
                    n_dropped++;
                end else begin
                    // stable placement: after every entry of equal or better priority
                    pos = 0;
                    while (pos < shadow_count && shadow_slots[pos].pri <= op.pri)
                        pos++;
                    for (k = shadow_count; k > pos; k--)
                        shadow_slots[k] = shadow_slots[k-1];
                    shadow_slots[pos].tag     = op.tag;
                    shadow_slots[pos].payload = op.payload;
                    shadow_slots[pos].pri     = op.pri;
                    shadow_count++;
                end
            end
            KIND_REMOVE, KIND_PEEK: begin
                if (shadow_count == 0) begin
                    r.status = STAT_NONE;
                    r.pri    = NONE_PRIORITY;
                    n_missing++;
                end else begin
                    r.tag     = shadow_slots[0].tag;
                    r.payload = shadow_slots[0].payload;
                    r.pri     = shadow_slots[0].pri;
                    if (op.kind == KIND_REMOVE) begin
                        for (k = 1; k < shadow_count; k++)
                            shadow_slots[k-1] = shadow_slots[k];
                        shadow_count--;
                    end
                end
            end
            default: begin
                // first match in queue order
                for (k = 0; k < shadow_count && !hit; k++) begin
                    if (shadow_slots[k].tag == op.tag) begin
                        hit       = 1'b1;
                        r.tag     = shadow_slots[k].tag;
                        r.payload = shadow_slots[k].payload;
                        r.pri     = shadow_slots[k].pri;
                    end
                end
                if (hit) begin
                    n_search_hit++;
                end else begin
                    r.status = STAT_NONE;
                    r.pri    = NONE_PRIORITY;
                    n_missing++;
                end
            end
        endcase
        r.occ = shadow_count[4:0];
        return r;
    endfunction

    task automatic add_op(t_kind kind, logic [15:0] tag, logic [31:0] payload,
                          logic [1:0] pri);
        t_queue_op op;
        op.kind    = kind;
        op.tag     = tag;
        op.payload = payload;
        op.pri     = pri;
        op.drain   = 1'b0;
        pending_ops.push_back(op);
    endtask

    task automatic add_pause();
        t_queue_op op;
        op       = '{KIND_PEEK, 16'd0, 32'd0, 2'd0, 1'b1};
        pending_ops.push_back(op);
    endtask

    // tags mostly from a small pool so that searches hit and duplicates occur
    function automatic logic [15:0] pick_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(0, 15));
        else if (r < 85)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            return 16'($urandom);
    endfunction

    // monitor: both transfers sampled at the rising edge
    always @(posedge i_clk) begin
        t_queue_resp got;
        t_queue_resp want;
        op_taken  = i_rst_n && i_valid && o_ready;
        tail_calm = pending_ops.size() < CALM_TAIL;
        if (op_taken) begin
            expected_resps.push_back(apply_queue_op(offered_op));
            ops_accepted++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{t_status'(o_status), o_out_tag, o_out_payload, o_out_priority,
                    o_occupancy};
            if (expected_resps.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected response: status %0d tag %h pay %h pri %0d occ %0d",
                             $time, got.status, got.tag, got.payload, got.pri, got.occ);
            end else begin
                want = expected_resps.pop_front();
                resps_checked++;
                if (got.status !== want.status || got.tag !== want.tag ||
                    got.payload !== want.payload || got.pri !== want.pri ||
                    got.occ !== want.occ) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("[%0t] response %0d mismatch", $time, resps_checked);
                        $display("    expected: status %0d tag %h pay %h pri %0d occ %0d",
                                 want.status, want.tag, want.payload, want.pri, want.occ);
                        $display("    actual:   status %0d tag %h pay %h pri %0d occ %0d",
                                 got.status, got.tag, got.payload, got.pri, got.occ);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                         idle_cycles, expected_resps.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // sender: offers pending operations with random idle bursts
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            send_cycle++;
            if (send_cycle % 256 == 0)
                send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 25);
            if (i_valid && !op_taken) begin
                // keep offering the same operation
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_ops.size() > 0 && pending_ops[0].drain) begin
                // pause until every expected response has come back
                i_valid <= 1'b0;
                if (expected_resps.size() == 0) begin
                    void'(pending_ops.pop_front());
                    n_pauses++;
                end
            end else if (pending_ops.size() > 0) begin
                if (!tail_calm && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 11);
                    i_valid <= 1'b0;
                end else begin
                    offered_op = pending_ops.pop_front();
                    i_kind         <= offered_op.kind;
                    i_patient_tag  <= offered_op.tag;
                    i_payload      <= offered_op.payload;
                    i_priority_req <= offered_op.pri;
                    i_valid        <= 1'b1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off that backs up the queue
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            recv_cycle++;
            if (recv_cycle % 200 == 0)
                recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
            if (!holdoff_done && ops_accepted >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if (!tail_calm && $urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 11);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int remaining;
        int seg_len;
        int ins_pct;
        int r;
        int k;
        bit mid_pause_added;

        // directed: empty queue, extremes, equal priorities, duplicate tags, overflow
        add_op(KIND_PEEK,   16'h0000, 32'h0000_0000, 2'd0);
        add_op(KIND_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
        add_op(KIND_SEARCH, 16'h0000, 32'h0000_0000, 2'd0);
        add_op(KIND_INSERT, 16'h0000, 32'h0000_0000, 2'd3);
        add_op(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 2'd0);
        add_op(KIND_INSERT, 16'h0005, 32'hA5A5_A5A5, 2'd1);
        add_op(KIND_INSERT, 16'h0005, 32'h5A5A_5A5A, 2'd1);
        add_op(KIND_INSERT, 16'h0007, 32'h0000_0001, 2'd0);
        for (k = 0; k < 11; k++)
            add_op(KIND_INSERT, 16'(100 + k), $urandom, 2'(k % 4));
        // one past capacity
        add_op(KIND_INSERT, 16'h0042, 32'hDEAD_BEEF, 2'd0);
        add_op(KIND_SEARCH, 16'h0005, 32'h0000_0000, 2'd0);
        add_op(KIND_SEARCH, 16'hFFFF, 32'h0000_0000, 2'd0);
        add_op(KIND_SEARCH, 16'h1234, 32'h0000_0000, 2'd0);
        add_op(KIND_PEEK,   16'h0000, 32'h0000_0000, 2'd0);
        add_op(KIND_REMOVE, 16'h0000, 32'h0000_0000, 2'd0);
        add_pause();

        // random: segments that fill, drain or churn the queue
        remaining       = N_RANDOM;
        mid_pause_added = 1'b0;
        while (remaining > 0) begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       ins_pct = 70;
                1:       ins_pct = 20;
                default: ins_pct = 45;
            endcase
            for (k = 0; k < seg_len && remaining > 0; k++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    add_op(KIND_INSERT, pick_tag(), $urandom, 2'($urandom_range(0, 3)));
                else if (r < ins_pct + (100 - ins_pct) / 3)
                    add_op(KIND_REMOVE, 16'($urandom), $urandom, 2'($urandom_range(0, 3)));
                else if (r < ins_pct + 2 * (100 - ins_pct) / 3)
                    add_op(KIND_PEEK, 16'($urandom), $urandom, 2'($urandom_range(0, 3)));
                else
                    add_op(KIND_SEARCH, pick_tag(), $urandom, 2'($urandom_range(0, 3)));
                remaining--;
            end
            if (!mid_pause_added && remaining < N_RANDOM / 2) begin
                add_pause();
                mid_pause_added = 1'b1;
            end
        end

        // reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the stimulus to run out and the responses to come back
        while (pending_ops.size() > 0 || i_valid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d operations, checked %0d responses, %0d mismatches",
                 ops_accepted, resps_checked, mismatches);
        $display("  %0d inserts dropped on full, %0d empty or unmatched, %0d search hits, %0d pauses",
                 n_dropped, n_missing, n_search_hit, n_pauses);
        if (mismatches == 0 && expected_resps.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
